[rtl/mie_pkg.sv]
package mie_pkg;

	localparam logic [5:0] OP_BEQ   = 6'd4;
	localparam logic [5:0] OP_BNE   = 6'd5;
	localparam logic [5:0] OP_ADDI  = 6'd8;
	localparam logic [5:0] OP_SLTI  = 6'd10;
	localparam logic [5:0] OP_SLTIU = 6'd11;
	localparam logic [5:0] OP_ANDI  = 6'd12;
	localparam logic [5:0] OP_ORI   = 6'd13;
	localparam logic [5:0] OP_LUI   = 6'd15;
	localparam logic [5:0] OP_LB    = 6'd32;
	localparam logic [5:0] OP_LH    = 6'd33;
	localparam logic [5:0] OP_LW    = 6'd35;
	localparam logic [5:0] OP_LBU   = 6'd36;
	localparam logic [5:0] OP_LHU   = 6'd37;
	localparam logic [5:0] OP_SB    = 6'd40;
	localparam logic [5:0] OP_SH    = 6'd41;
	localparam logic [5:0] OP_SW    = 6'd43;

	localparam logic [3:0] FN_ADD  = 4'd0;
	localparam logic [3:0] FN_AND  = 4'd1;
	localparam logic [3:0] FN_OR   = 4'd2;
	localparam logic [3:0] FN_SLT  = 4'd3;
	localparam logic [3:0] FN_SLTU = 4'd4;
	localparam logic [3:0] FN_LUI  = 4'd5;
	localparam logic [3:0] FN_BEQ  = 4'd6;
	localparam logic [3:0] FN_BNE  = 4'd7;
	localparam logic [3:0] FN_BAD  = 4'd8;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;

	localparam int QDepth = 2;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef struct packed {
		logic [3:0]         fn;
		logic               mem_request;
		logic               mem_write;
		logic [1:0]         access_size;
		logic               load_unsigned;
		logic               is_branch;
		logic               bad_opcode;
		logic [4:0]         rs_index;
		logic [4:0]         rt_index;
		logic signed [15:0] immediate;
		logic signed [31:0] rs_value;
		logic signed [31:0] rt_value;
		logic [31:0]        current_pc;
	} uop_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic [4:0]  dest_index;
		logic [4:0]  source_index;
		logic        mem_request;
		logic        mem_write;
		logic [1:0]  access_size;
		logic        load_unsigned;
		logic        is_branch;
		logic        bad_opcode;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

[rtl/mie_front.sv]
module mie_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [5:0]            command,
	input  logic [4:0]            rs_index,
	input  logic [4:0]            rt_index,
	input  logic signed [15:0]    immediate,
	input  logic signed [31:0]    rs_value,
	input  logic signed [31:0]    rt_value,
	input  logic [31:0]           current_pc,
	input  mie_pkg::qstat_t       qstat,
	output logic                  push,
	output mie_pkg::uop_t         push_uop
);
	import mie_pkg::*;

	logic  v_s1;
	uop_t  uop_s1;
	uop_t  dec;
	logic  accept;

	always_comb begin
		dec               = '0;
		dec.fn            = FN_BAD;
		dec.bad_opcode    = 1'b1;
		dec.rs_index      = rs_index;
		dec.rt_index      = rt_index;
		dec.immediate     = immediate;
		dec.rs_value      = rs_value;
		dec.rt_value      = rt_value;
		dec.current_pc    = current_pc;
		case (command)
			OP_ADDI:  begin dec.fn = FN_ADD;  dec.bad_opcode = 1'b0; end
			OP_ANDI:  begin dec.fn = FN_AND;  dec.bad_opcode = 1'b0; end
			OP_ORI:   begin dec.fn = FN_OR;   dec.bad_opcode = 1'b0; end
			OP_SLTI:  begin dec.fn = FN_SLT;  dec.bad_opcode = 1'b0; end
			OP_SLTIU: begin dec.fn = FN_SLTU; dec.bad_opcode = 1'b0; end
			OP_LUI:   begin dec.fn = FN_LUI;  dec.bad_opcode = 1'b0; end
			OP_BEQ: begin
				dec.fn = FN_BEQ; dec.is_branch = 1'b1; dec.bad_opcode = 1'b0;
			end
			OP_BNE: begin
				dec.fn = FN_BNE; dec.is_branch = 1'b1; dec.bad_opcode = 1'b0;
			end
			OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: begin
				dec.fn            = FN_ADD;
				dec.bad_opcode    = 1'b0;
				dec.mem_request   = 1'b1;
				dec.mem_write     = command inside {OP_SB, OP_SH, OP_SW};
				dec.load_unsigned = command inside {OP_LBU, OP_LHU};
				if (command inside {OP_LW, OP_SW}) begin
					dec.access_size = SZ_WORD;
				end else if (command inside {OP_LH, OP_LHU, OP_SH}) begin
					dec.access_size = SZ_HALF;
				end else begin
					dec.access_size = SZ_BYTE;
				end
			end
			default: begin
				dec.fn         = FN_BAD;
				dec.bad_opcode = 1'b1;
			end
		endcase
	end

	assign push     = v_s1 && !qstat.full;
	assign busy     = v_s1 && qstat.full;
	assign accept   = start && !busy;
	assign push_uop = uop_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			uop_s1 <= dec;
		end
	end

endmodule

[rtl/mie_queue.sv]
module mie_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mie_pkg::uop_t    push_uop,
	input  logic             pop,
	output mie_pkg::uop_t    pop_uop,
	output mie_pkg::qstat_t  qstat
);
	import mie_pkg::*;

	uop_t             ent_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign qstat.full  = (cnt_q == QCntW'(QDepth));
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign pop_uop     = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_uop;
		end
	end

endmodule

[rtl/mie_back.sv]
module mie_back (
	input  logic           clk,
	input  logic           arst_n,
	input  mie_pkg::qstat_t qstat,
	input  mie_pkg::uop_t  uop,
	output logic           pop,
	output logic           done,
	output mie_pkg::res_t  res
);
	import mie_pkg::*;

	logic [31:0] sx;
	logic [31:0] zx;
	logic [31:0] sum;
	logic [31:0] pc_tgt;
	logic        slt;
	logic        sltu;
	logic        eq;
	res_t        r;
	logic        done_q;
	res_t        res_q;

	assign pop    = !qstat.empty;
	assign sx     = {{16{uop.immediate[15]}}, uop.immediate};
	assign zx     = {16'h0000, uop.immediate};
	assign sum    = uop.rs_value + sx;
	assign pc_tgt = uop.current_pc + sx;
	assign slt    = uop.rs_value < $signed(sx);
	assign sltu   = $unsigned(uop.rs_value) < sx;
	assign eq     = (uop.rs_value == uop.rt_value);

	always_comb begin
		r               = '0;
		r.dest_index    = uop.rt_index;
		r.source_index  = uop.rs_index;
		r.mem_request   = uop.mem_request;
		r.mem_write     = uop.mem_write;
		r.access_size   = uop.access_size;
		r.load_unsigned = uop.load_unsigned;
		r.is_branch     = uop.is_branch;
		r.bad_opcode    = uop.bad_opcode;
		case (uop.fn)
			FN_ADD:  r.result_value = sum;
			FN_AND:  r.result_value = uop.rs_value & zx;
			FN_OR:   r.result_value = uop.rs_value | zx;
			FN_SLT:  r.result_value = {31'd0, slt};
			FN_SLTU: r.result_value = {31'd0, sltu};
			FN_LUI:  r.result_value = {uop.immediate, 16'h0000};
			FN_BEQ:  r.result_value = eq ? pc_tgt : uop.current_pc;
			FN_BNE:  r.result_value = eq ? uop.current_pc : pc_tgt;
			default: r.result_value = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= r;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[rtl/mips_itype_execute.sv]
// channel  | handshake           | fields
// ---------+---------------------+---------------------------------------------
// command  | start & !busy       | command, rs_index, rt_index, immediate,
//          |                     | rs_value, rt_value, current_pc
// result   | done (result valid) | result_value, dest_index, source_index,
//          |                     | mem_request, mem_write, access_size,
//          |                     | load_unsigned, is_branch, bad_opcode
//
// One transaction per cycle sustained; an accepted command passes through the
// decode register, the 2-entry queue and the execute output register, and done
// rises as the result is loaded into the output register.
// Reset clears the decode valid, queue pointers and done; payload is not reset.
// No result backpressure: the back end drains every cycle the queue is not
// empty; busy rises only if the queue fills, which this drain rate prevents.
module mips_itype_execute (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [5:0]         command,
	input  logic [4:0]         rs_index,
	input  logic [4:0]         rt_index,
	input  logic signed [15:0] immediate,
	input  logic signed [31:0] rs_value,
	input  logic signed [31:0] rt_value,
	input  logic [31:0]        current_pc,
	output logic               done,
	output logic [31:0]        result_value,
	output logic [4:0]         dest_index,
	output logic [4:0]         source_index,
	output logic               mem_request,
	output logic               mem_write,
	output logic [1:0]         access_size,
	output logic               load_unsigned,
	output logic               is_branch,
	output logic               bad_opcode
);
	import mie_pkg::*;

	qstat_t qstat;
	logic   push;
	uop_t   push_uop;
	logic   pop;
	uop_t   pop_uop;
	res_t   res;

	mie_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.rs_index   (rs_index),
		.rt_index   (rt_index),
		.immediate  (immediate),
		.rs_value   (rs_value),
		.rt_value   (rt_value),
		.current_pc (current_pc),
		.qstat      (qstat),
		.push       (push),
		.push_uop   (push_uop)
	);

	mie_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_uop (push_uop),
		.pop      (pop),
		.pop_uop  (pop_uop),
		.qstat    (qstat)
	);

	mie_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.uop    (pop_uop),
		.pop    (pop),
		.done   (done),
		.res    (res)
	);

	assign result_value  = res.result_value;
	assign dest_index    = res.dest_index;
	assign source_index  = res.source_index;
	assign mem_request   = res.mem_request;
	assign mem_write     = res.mem_write;
	assign access_size   = res.access_size;
	assign load_unsigned = res.load_unsigned;
	assign is_branch     = res.is_branch;
	assign bad_opcode    = res.bad_opcode;

endmodule
